// ===== rtl/tlcp_pkg.sv =====
// Shared types and constants of the traffic light controller with pedestrian crossing.
// No dependencies; every other file of the block but tlcp_if imports this package.
package tlcp_pkg;

  localparam int SEC_W      = 8;
  localparam int SEC_MAX    = (1 << SEC_W) - 1;
  localparam int HOLD_SEC   = 10;
  localparam int CLEAR_SEC  = 3;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GREEN_A  = 3'd0,
    REG_YELLOW_A = 3'd1,
    REG_RED_A    = 3'd2,
    REG_GREEN_B  = 3'd3,
    REG_YELLOW_B = 3'd4,
    REG_RED_B    = 3'd5,
    REG_WALK     = 3'd6,
    REG_BLINK    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    COL_GREEN  = 2'd0,
    COL_YELLOW = 2'd1,
    COL_RED    = 2'd2
  } colour_t;

  typedef enum logic [2:0] {
    WALK_IDLE  = 3'd0,
    WALK_HOLD  = 3'd1,
    WALK_CLEAR = 3'd2,
    WALK_ON    = 3'd3,
    WALK_FLASH = 3'd4
  } walk_phase_t;

  typedef struct packed {
    logic advance;
    logic restart;
  } appr_ctl_t;

  typedef struct packed {
    appr_ctl_t appr;
    logic      force_yellow;
    logic      force_red;
  } walk_ctl_t;

  typedef struct packed {
    logic green;
    logic yellow;
    logic red;
  } lamp3_t;

  function automatic colour_t next_colour(colour_t c);
    case (c)
      COL_GREEN:  return COL_YELLOW;
      COL_YELLOW: return COL_RED;
      default:    return COL_GREEN;
    endcase
  endfunction

endpackage

// ===== rtl/tlcp_if.sv =====
// Valid/ready channel interfaces for the tick input and the lamp result.
// Carries no types of its own; the payload is plain single-bit lamps and button.
interface tlcp_in_if;
  logic valid;
  logic ready;
  logic ped_request;

  modport source (output valid, output ped_request, input ready);
  modport sink   (input valid, input ped_request, output ready);
endinterface

interface tlcp_out_if;
  logic valid;
  logic ready;
  logic lamp_a_green;
  logic lamp_a_yellow;
  logic lamp_a_red;
  logic lamp_b_green;
  logic lamp_b_yellow;
  logic lamp_b_red;
  logic lamp_walk;
  logic lamp_dont_walk;

  modport source (output valid, output lamp_a_green, output lamp_a_yellow, output lamp_a_red,
                  output lamp_b_green, output lamp_b_yellow, output lamp_b_red,
                  output lamp_walk, output lamp_dont_walk, input ready);
  modport sink   (input valid, input lamp_a_green, input lamp_a_yellow, input lamp_a_red,
                  input lamp_b_green, input lamp_b_yellow, input lamp_b_red,
                  input lamp_walk, input lamp_dont_walk, output ready);
endinterface

// ===== rtl/tlcp_approach.sv =====
// Phase sequencer for one vehicle approach: cycling, flashing yellow or dark.
// Depends on tlcp_pkg for colour, control and lamp types.
module tlcp_approach #(
  parameter int                TICKS_PER_SECOND = 4,
  parameter int                TICK_W           = 10,
  parameter tlcp_pkg::colour_t START_COLOUR     = tlcp_pkg::COL_GREEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tlcp_pkg::SEC_W-1:0] green_sec,
  input  logic [tlcp_pkg::SEC_W-1:0] yellow_sec,
  input  logic [tlcp_pkg::SEC_W-1:0] red_sec,
  input  logic                       blink,
  input  tlcp_pkg::appr_ctl_t        ctl,
  output tlcp_pkg::lamp3_t           lamps
);
  import tlcp_pkg::*;

  localparam int BLINK_PERIOD = 2 * TICKS_PER_SECOND;

  colour_t            phase, phase_next;
  logic [TICK_W-1:0]  ticks, ticks_next;
  logic               dark;
  colour_t            ld_base, ld_c1, ld_c2, ld_col;
  logic [SEC_W-1:0]   ld_sec;
  logic [TICK_W-1:0]  ld_ticks;

  function automatic logic [SEC_W-1:0] sec_of(colour_t c, logic [SEC_W-1:0] g,
                                               logic [SEC_W-1:0] y, logic [SEC_W-1:0] r);
    case (c)
      COL_GREEN:  return g;
      COL_YELLOW: return y;
      default:    return r;
    endcase
  endfunction

  assign dark = ((green_sec | yellow_sec | red_sec) == '0) && !blink;

  // Find the first phase of non-zero length, starting at the requested colour
  always_comb begin
    ld_base = ctl.restart ? START_COLOUR : next_colour(phase);
    ld_c1   = next_colour(ld_base);
    ld_c2   = next_colour(ld_c1);
    if (sec_of(ld_base, green_sec, yellow_sec, red_sec) != '0) begin
      ld_col = ld_base;
    end else if (sec_of(ld_c1, green_sec, yellow_sec, red_sec) != '0) begin
      ld_col = ld_c1;
    end else if (sec_of(ld_c2, green_sec, yellow_sec, red_sec) != '0) begin
      ld_col = ld_c2;
    end else begin
      ld_col = ld_base;
    end
    ld_sec   = sec_of(ld_col, green_sec, yellow_sec, red_sec);
    ld_ticks = TICK_W'(32'(ld_sec) * TICKS_PER_SECOND);
  end

  always_comb begin
    phase_next = phase;
    ticks_next = ticks;
    if (ctl.restart) begin
      phase_next = ld_col;
      ticks_next = blink ? '0 : ld_ticks;
    end else if (ctl.advance) begin
      if (blink) begin
        ticks_next = (ticks == TICK_W'(BLINK_PERIOD - 1)) ? '0 : ticks + TICK_W'(1);
      end else if (!dark) begin
        if (ticks <= TICK_W'(1)) begin
          phase_next = ld_col;
          ticks_next = ld_ticks;
        end else begin
          ticks_next = ticks - TICK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= START_COLOUR;
      ticks <= '0;
    end else begin
      phase <= phase_next;
      ticks <= ticks_next;
    end
  end

  always_comb begin
    lamps = '0;
    if (blink) begin
      lamps.yellow = ticks < TICK_W'(TICKS_PER_SECOND);
    end else if (!dark) begin
      lamps.green  = (phase == COL_GREEN);
      lamps.yellow = (phase == COL_YELLOW);
      lamps.red    = (phase == COL_RED);
    end
  end

  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    blink && !ctl.restart |-> ticks < TICK_W'(BLINK_PERIOD))
    else $error("blink counter out of range");

  a_cycle_loaded: assert property (@(posedge clk) disable iff (rst)
    !blink && !dark && !ctl.restart |-> ticks != '0)
    else $error("cycling approach with empty phase timer");

  a_one_lamp: assert property (@(posedge clk) disable iff (rst)
    $onehot0(lamps))
    else $error("more than one lamp lit on approach");

endmodule

// ===== rtl/tlcp_walk.sv =====
// Pedestrian crossing sequencer: hold, clearance, walk and flashing don't-walk.
// Depends on tlcp_pkg for the phase enum and the control struct.
module tlcp_walk #(
  parameter int TICKS_PER_SECOND = 4,
  parameter int WALK_FLASHES     = 10,
  parameter int TICK_W           = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       ped_request,
  input  logic                       cfg_restart,
  input  logic [tlcp_pkg::SEC_W-1:0] walk_sec,
  output tlcp_pkg::walk_ctl_t        ctl,
  output logic                       lamp_walk,
  output logic                       lamp_dont_walk
);
  import tlcp_pkg::*;

  localparam int HALF_FLASH   = (TICKS_PER_SECOND + 3) / 4;
  localparam int FLASH_PERIOD = 2 * HALF_FLASH;
  localparam int HOLD_TICKS   = HOLD_SEC * TICKS_PER_SECOND;
  localparam int CLEAR_TICKS  = CLEAR_SEC * TICKS_PER_SECOND;
  localparam int FLASH_W      = $clog2(WALK_FLASHES + 1);

  walk_phase_t         phase, phase_next;
  logic [TICK_W-1:0]   ticks, ticks_next;
  logic [FLASH_W-1:0]  flashes, flashes_next;
  logic                enabled;
  logic                running;
  logic                finish;
  logic                last_tick;

  assign enabled   = (walk_sec != '0);
  assign running   = !enabled || (phase == WALK_IDLE) || (phase == WALK_HOLD);
  assign last_tick = (ticks <= TICK_W'(1));

  always_comb begin
    phase_next   = phase;
    ticks_next   = ticks;
    flashes_next = flashes;
    finish       = 1'b0;
    if (cfg_restart || (step && !enabled)) begin
      phase_next   = WALK_IDLE;
      ticks_next   = '0;
      flashes_next = '0;
    end else if (step) begin
      case (phase)
        WALK_IDLE: begin
          if (ped_request) begin
            phase_next = WALK_HOLD;
            ticks_next = TICK_W'(HOLD_TICKS);
          end
        end
        WALK_HOLD: begin
          if (last_tick) begin
            phase_next = WALK_CLEAR;
            ticks_next = TICK_W'(CLEAR_TICKS);
          end else begin
            ticks_next = ticks - TICK_W'(1);
          end
        end
        WALK_CLEAR: begin
          if (last_tick) begin
            phase_next = WALK_ON;
            ticks_next = TICK_W'(32'(walk_sec) * TICKS_PER_SECOND);
          end else begin
            ticks_next = ticks - TICK_W'(1);
          end
        end
        WALK_ON: begin
          if (last_tick) begin
            phase_next   = WALK_FLASH;
            ticks_next   = TICK_W'(FLASH_PERIOD);
            flashes_next = '0;
          end else begin
            ticks_next = ticks - TICK_W'(1);
          end
        end
        WALK_FLASH: begin
          if (last_tick) begin
            if ((flashes + FLASH_W'(1)) >= FLASH_W'(WALK_FLASHES)) begin
              finish       = 1'b1;
              phase_next   = WALK_IDLE;
              ticks_next   = '0;
              flashes_next = '0;
            end else begin
              ticks_next   = TICK_W'(FLASH_PERIOD);
              flashes_next = flashes + FLASH_W'(1);
            end
          end else begin
            ticks_next = ticks - TICK_W'(1);
          end
        end
        default: begin
          phase_next   = WALK_IDLE;
          ticks_next   = '0;
          flashes_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= WALK_IDLE;
      ticks   <= '0;
      flashes <= '0;
    end else begin
      phase   <= phase_next;
      ticks   <= ticks_next;
      flashes <= flashes_next;
    end
  end

  always_comb begin
    ctl.appr.advance = step && running;
    ctl.appr.restart = cfg_restart || finish;
    ctl.force_yellow = enabled && (phase == WALK_CLEAR);
    ctl.force_red    = enabled && ((phase == WALK_ON) || (phase == WALK_FLASH));
    lamp_walk        = enabled && (phase == WALK_ON);
    lamp_dont_walk   = enabled && ((phase == WALK_IDLE) || (phase == WALK_HOLD) ||
                       ((phase == WALK_FLASH) && (ticks > TICK_W'(HALF_FLASH))));
  end

  a_flash_bound: assert property (@(posedge clk) disable iff (rst)
    phase == WALK_FLASH |-> flashes < FLASH_W'(WALK_FLASHES))
    else $error("flash count overran");

  a_timer_live: assert property (@(posedge clk) disable iff (rst)
    phase != WALK_IDLE |-> ticks != '0)
    else $error("sequence phase with empty timer");

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    ctl.appr.advance |-> !ctl.force_yellow && !ctl.force_red)
    else $error("approaches advanced while overridden");

  a_start: assert property (@(posedge clk) disable iff (rst)
    step && enabled && !cfg_restart && phase == WALK_IDLE && ped_request
      |=> phase == WALK_HOLD)
    else $error("request while idle did not start the sequence");

endmodule

// ===== rtl/traffic_light_controller_ped.sv =====
// Top level of the traffic light controller with pedestrian crossing.
// Depends on tlcp_pkg, tlcp_if, tlcp_approach and tlcp_walk.
//
// Each transfer on the tick channel is one tick of 1/TICKS_PER_SECOND second carrying
// a sample of the pedestrian button; for each one the block returns exactly one
// transfer on the lamps channel showing the eight lamps during that tick. A tick is
// taken in every clock cycle while the result register is empty or being drained and
// no restart is pending, so the sustained rate is one tick per clock between writes,
// and a result appears in the cycle after its tick; all per-tick work (timer decrement,
// phase search, sequencer step) sits in one level of logic between the state registers
// and the result register. The eight phase and walk-time registers sit on the APB port
// at byte address 4*i; any write restarts both approaches and returns the crossing to
// idle, which takes the cycle after the write, during which no tick is taken.
module traffic_light_controller_ped #(
  parameter int TICKS_PER_SECOND = 4,
  parameter int WALK_FLASHES     = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  tlcp_in_if.sink                         tick,
  tlcp_out_if.source                      lamps,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlcp_pkg::ADDR_W-1:0]     paddr,
  input  logic [tlcp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tlcp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tlcp_pkg::*;

  // Widest timer: longest phase at the configured tick rate
  localparam int TICK_W = $clog2(SEC_MAX * TICKS_PER_SECOND + 1);

  logic [SEC_W-1:0] green_a_sec, yellow_a_sec, red_a_sec;
  logic [SEC_W-1:0] green_b_sec, yellow_b_sec, red_b_sec;
  logic [SEC_W-1:0] walk_sec;
  logic [1:0]       blink_mask;
  logic             restart_pending;
  logic             cfg_write;
  cfg_reg_t         cfg_idx;
  logic             step;
  walk_ctl_t        wctl;
  lamp3_t           appr_a, appr_b, shown_a, shown_b;
  logic             walk_lamp, dont_walk_lamp;

  // Configuration port: zero-wait APB, writes land at the access edge
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = cfg_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      green_a_sec     <= '0;
      yellow_a_sec    <= '0;
      red_a_sec       <= '0;
      green_b_sec     <= '0;
      yellow_b_sec    <= '0;
      red_b_sec       <= '0;
      walk_sec        <= '0;
      blink_mask      <= '0;
      restart_pending <= 1'b0;
    end else begin
      // Hold off ticks in the cycle after each write so the restart sees the new value
      restart_pending <= cfg_write;
      if (cfg_write) begin
        case (cfg_idx)
          REG_GREEN_A:  green_a_sec  <= pwdata[SEC_W-1:0];
          REG_YELLOW_A: yellow_a_sec <= pwdata[SEC_W-1:0];
          REG_RED_A:    red_a_sec    <= pwdata[SEC_W-1:0];
          REG_GREEN_B:  green_b_sec  <= pwdata[SEC_W-1:0];
          REG_YELLOW_B: yellow_b_sec <= pwdata[SEC_W-1:0];
          REG_RED_B:    red_b_sec    <= pwdata[SEC_W-1:0];
          REG_WALK:     walk_sec     <= pwdata[SEC_W-1:0];
          REG_BLINK:    blink_mask   <= pwdata[1:0];
          default:      ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GREEN_A:  prdata = APB_DATA_W'(green_a_sec);
      REG_YELLOW_A: prdata = APB_DATA_W'(yellow_a_sec);
      REG_RED_A:    prdata = APB_DATA_W'(red_a_sec);
      REG_GREEN_B:  prdata = APB_DATA_W'(green_b_sec);
      REG_YELLOW_B: prdata = APB_DATA_W'(yellow_b_sec);
      REG_RED_B:    prdata = APB_DATA_W'(red_b_sec);
      REG_WALK:     prdata = APB_DATA_W'(walk_sec);
      REG_BLINK:    prdata = APB_DATA_W'(blink_mask);
      default:      prdata = '0;
    endcase
  end

  // Take a tick whenever the result register is free or drains this cycle
  assign tick.ready = !restart_pending && (!lamps.valid || lamps.ready);
  assign step       = tick.valid && tick.ready;

  tlcp_walk #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .WALK_FLASHES     (WALK_FLASHES),
    .TICK_W           (TICK_W)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .ped_request    (tick.ped_request),
    .cfg_restart    (restart_pending),
    .walk_sec       (walk_sec),
    .ctl            (wctl),
    .lamp_walk      (walk_lamp),
    .lamp_dont_walk (dont_walk_lamp)
  );

  tlcp_approach #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .TICK_W           (TICK_W),
    .START_COLOUR     (COL_GREEN)
  ) u_appr_a (
    .clk        (clk),
    .rst        (rst),
    .green_sec  (green_a_sec),
    .yellow_sec (yellow_a_sec),
    .red_sec    (red_a_sec),
    .blink      (blink_mask[0]),
    .ctl        (wctl.appr),
    .lamps      (appr_a)
  );

  tlcp_approach #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .TICK_W           (TICK_W),
    .START_COLOUR     (COL_RED)
  ) u_appr_b (
    .clk        (clk),
    .rst        (rst),
    .green_sec  (green_b_sec),
    .yellow_sec (yellow_b_sec),
    .red_sec    (red_b_sec),
    .blink      (blink_mask[1]),
    .ctl        (wctl.appr),
    .lamps      (appr_b)
  );

  // Crossing sequence overrides both approaches, dark or flashing included
  always_comb begin
    shown_a = appr_a;
    shown_b = appr_b;
    if (wctl.force_yellow) begin
      shown_a = '{green: 1'b0, yellow: 1'b1, red: 1'b0};
      shown_b = '{green: 1'b0, yellow: 1'b1, red: 1'b0};
    end else if (wctl.force_red) begin
      shown_a = '{green: 1'b0, yellow: 1'b0, red: 1'b1};
      shown_b = '{green: 1'b0, yellow: 1'b0, red: 1'b1};
    end
  end

  // Result register: valid is control, lamps are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      lamps.valid <= 1'b0;
    end else if (step) begin
      lamps.valid <= 1'b1;
    end else if (lamps.ready) begin
      lamps.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lamps.lamp_a_green   <= shown_a.green;
      lamps.lamp_a_yellow  <= shown_a.yellow;
      lamps.lamp_a_red     <= shown_a.red;
      lamps.lamp_b_green   <= shown_b.green;
      lamps.lamp_b_yellow  <= shown_b.yellow;
      lamps.lamp_b_red     <= shown_b.red;
      lamps.lamp_walk      <= walk_lamp;
      lamps.lamp_dont_walk <= dont_walk_lamp;
    end
  end

  a_restart_stall: assert property (@(posedge clk) disable iff (rst)
    restart_pending |-> !tick.ready)
    else $error("tick taken during configuration restart");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> lamps.valid)
    else $error("tick transfer produced no result");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !lamps.valid && !restart_pending |-> tick.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for traffic_light_controller_ped: ticks in, lamp sets out, APB set-up.
// Depends on tlcp_pkg, tlcp_in_if, tlcp_out_if and the block's RTL; nothing else.
module testbench;
  import tlcp_pkg::*;

  localparam int TICK_RATE    = 4;    // ticks per second
  localparam int FLASH_COUNT  = 10;   // don't-walk flashes closing a crossing
  localparam int HALF_FLASH   = (TICK_RATE + 3) / 4;
  localparam int TICK_TARGET  = 1600;
  localparam int TAIL_CYCLES  = 20;
  localparam int LIMIT_NS     = 2_000_000;

  typedef enum logic [1:0] {MODE_DARK, MODE_BLINK, MODE_CYCLE} appr_mode_t;
  typedef enum logic {ITEM_TICK, ITEM_WRITE} item_kind_t;

  typedef struct packed {
    logic a_green;
    logic a_yellow;
    logic a_red;
    logic b_green;
    logic b_yellow;
    logic b_red;
    logic walk;
    logic dont_walk;
  } lamp_set_t;

  typedef struct {
    item_kind_t  kind;
    logic        press;     // button sample of a tick
    logic        pause;     // hold the tick back until every lamp set is home
    cfg_reg_t    cfg_idx;
    logic [31:0] value;
  } stim_item_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tlcp_in_if  tick_bus ();
  tlcp_out_if lamp_bus ();

  // ------------------------------------------------------------------
  // Stimulus store, expected lamp sets and run statistics
  // ------------------------------------------------------------------
  stim_item_t  pending[$];
  lamp_set_t   lamps_due[$];
  int unsigned planned_ticks  = 0;
  int unsigned ticks_taken    = 0;
  int unsigned lamps_checked  = 0;
  int unsigned writes_done    = 0;
  int unsigned crossings_done = 0;
  int unsigned pauses_done    = 0;
  int unsigned lamp_faults    = 0;
  bit          pause_planned  = 1'b0;

  string lamp_names [8] = '{"lamp_a_green", "lamp_a_yellow", "lamp_a_red",
                            "lamp_b_green", "lamp_b_yellow", "lamp_b_red",
                            "lamp_walk", "lamp_dont_walk"};

  // Own copy of the controller: settings and state
  logic [7:0]  phase_secs [2][3];   // [approach][colour]
  logic [7:0]  walk_secs;
  logic [1:0]  blink_bits;
  colour_t     appr_col   [2];
  int unsigned appr_ticks [2];
  walk_phase_t walk_ph;
  int unsigned walk_ticks;
  int unsigned flash_done;

  int gap_left;
  int stall_left;

  traffic_light_controller_ped #(
    .TICKS_PER_SECOND (TICK_RATE),
    .WALK_FLASHES     (FLASH_COUNT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_bus),
    .lamps   (lamp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Controller model
  // ------------------------------------------------------------------
  function automatic logic [7:0] sec_of(int b, colour_t c);
    return phase_secs[b][int'(c)];
  endfunction

  function automatic appr_mode_t appr_mode(int b);
    if (blink_bits[b]) return MODE_BLINK;
    if ((sec_of(b, COL_GREEN) | sec_of(b, COL_YELLOW) | sec_of(b, COL_RED)) == '0) begin
      return MODE_DARK;
    end
    return MODE_CYCLE;
  endfunction

  // Take the first phase of non-zero length from the given colour on
  function automatic void load_phase(int b, colour_t col);
    colour_t c;
    c = col;
    for (int i = 0; i < 3; i++) begin
      if (sec_of(b, c) != '0) begin
        appr_col[b]   = c;
        appr_ticks[b] = sec_of(b, c) * TICK_RATE;
        return;
      end
      c = next_colour(c);
    end
    appr_col[b]   = col;
    appr_ticks[b] = 0;
  endfunction

  function automatic void restart_all();
    for (int b = 0; b < 2; b++) begin
      load_phase(b, (b != 0) ? COL_RED : COL_GREEN);
      if (appr_mode(b) == MODE_BLINK) appr_ticks[b] = 0;
    end
    walk_ph    = WALK_IDLE;
    walk_ticks = 0;
    flash_done = 0;
  endfunction

  function automatic void model_reset();
    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < 3; c++) phase_secs[b][c] = '0;
    end
    walk_secs  = '0;
    blink_bits = '0;
    restart_all();
  endfunction

  function automatic void model_config(cfg_reg_t idx, logic [31:0] v);
    case (idx)
      REG_GREEN_A:  phase_secs[0][int'(COL_GREEN)]  = v[7:0];
      REG_YELLOW_A: phase_secs[0][int'(COL_YELLOW)] = v[7:0];
      REG_RED_A:    phase_secs[0][int'(COL_RED)]    = v[7:0];
      REG_GREEN_B:  phase_secs[1][int'(COL_GREEN)]  = v[7:0];
      REG_YELLOW_B: phase_secs[1][int'(COL_YELLOW)] = v[7:0];
      REG_RED_B:    phase_secs[1][int'(COL_RED)]    = v[7:0];
      REG_WALK:     walk_secs  = v[7:0];
      REG_BLINK:    blink_bits = v[1:0];
      default:      ;
    endcase
    restart_all();
  endfunction

  // Lamps of one approach as {green, yellow, red}
  function automatic logic [2:0] appr_lamps(int b);
    appr_mode_t m;
    logic [2:0] l;
    m = appr_mode(b);
    l = '0;
    if (m == MODE_BLINK) begin
      l[1] = (appr_ticks[b] < TICK_RATE);
    end else if (m == MODE_CYCLE) begin
      l = {appr_col[b] == COL_GREEN, appr_col[b] == COL_YELLOW, appr_col[b] == COL_RED};
    end
    return l;
  endfunction

  function automatic void appr_advance(int b);
    appr_mode_t m;
    m = appr_mode(b);
    if (m == MODE_BLINK) begin
      appr_ticks[b] = (appr_ticks[b] + 1) % (2 * TICK_RATE);
    end else if (m == MODE_CYCLE) begin
      if (appr_ticks[b] <= 1) load_phase(b, next_colour(appr_col[b]));
      else appr_ticks[b] = appr_ticks[b] - 1;
    end
  endfunction

  // One tick: lamps shown during the tick, then advance the state
  function automatic lamp_set_t model_step(logic press);
    logic [2:0] la;
    logic [2:0] lb;
    logic       walk;
    logic       dont;
    if (walk_secs == '0) begin
      walk_ph    = WALK_IDLE;
      walk_ticks = 0;
      flash_done = 0;
    end
    la   = appr_lamps(0);
    lb   = appr_lamps(1);
    walk = 1'b0;
    dont = 1'b0;
    if (walk_ph == WALK_CLEAR) begin
      la = 3'b010;
      lb = 3'b010;
    end else if (walk_ph == WALK_ON || walk_ph == WALK_FLASH) begin
      la = 3'b001;
      lb = 3'b001;
    end
    if (walk_secs != '0) begin
      if (walk_ph == WALK_IDLE || walk_ph == WALK_HOLD) dont = 1'b1;
      else if (walk_ph == WALK_ON) walk = 1'b1;
      else if (walk_ph == WALK_FLASH) dont = (walk_ticks > HALF_FLASH);
    end
    if (walk_ph == WALK_IDLE || walk_ph == WALK_HOLD) begin
      appr_advance(0);
      appr_advance(1);
    end
    if (walk_secs != '0) begin
      case (walk_ph)
        WALK_IDLE: begin
          if (press) begin
            walk_ph    = WALK_HOLD;
            walk_ticks = HOLD_SEC * TICK_RATE;
          end
        end
        WALK_HOLD: begin
          if (walk_ticks <= 1) begin
            walk_ph    = WALK_CLEAR;
            walk_ticks = CLEAR_SEC * TICK_RATE;
          end else walk_ticks = walk_ticks - 1;
        end
        WALK_CLEAR: begin
          if (walk_ticks <= 1) begin
            walk_ph    = WALK_ON;
            walk_ticks = walk_secs * TICK_RATE;
          end else walk_ticks = walk_ticks - 1;
        end
        WALK_ON: begin
          if (walk_ticks <= 1) begin
            walk_ph    = WALK_FLASH;
            walk_ticks = 2 * HALF_FLASH;
            flash_done = 0;
          end else walk_ticks = walk_ticks - 1;
        end
        WALK_FLASH: begin
          if (walk_ticks <= 1) begin
            flash_done = flash_done + 1;
            if (flash_done >= FLASH_COUNT) begin
              restart_all();
              crossings_done = crossings_done + 1;
            end else walk_ticks = 2 * HALF_FLASH;
          end else walk_ticks = walk_ticks - 1;
        end
        default: begin
          walk_ph    = WALK_IDLE;
          walk_ticks = 0;
          flash_done = 0;
        end
      endcase
    end
    return {la, lb, walk, dont};
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic [7:0] pick_secs();
    int r;
    r = int'($urandom_range(0, 19));
    if (r < 4) return 8'd0;
    if (r < 16) return 8'($urandom_range(1, 3));
    if (r < 19) return 8'($urandom_range(4, 12));
    return 8'd255;
  endfunction

  function automatic void add_write(cfg_reg_t idx, logic [7:0] v);
    stim_item_t it;
    it.kind    = ITEM_WRITE;
    it.press   = 1'b0;
    it.pause   = 1'b0;
    it.cfg_idx = idx;
    // Junk in the unused upper bits must be dropped by the block
    if (idx == REG_BLINK) it.value = ($urandom() & 32'hFFFF_FFFC) | {30'd0, v[1:0]};
    else it.value = ($urandom() & 32'hFFFF_FF00) | {24'd0, v};
    pending.push_back(it);
  endfunction

  function automatic void add_tick(logic press, logic pause);
    stim_item_t it;
    it.kind    = ITEM_TICK;
    it.press   = press;
    it.pause   = pause;
    it.cfg_idx = REG_GREEN_A;
    it.value   = '0;
    pending.push_back(it);
    planned_ticks = planned_ticks + 1;
  endfunction

  task automatic check_lamps(lamp_set_t due, lamp_set_t seen);
    for (int i = 0; i < 8; i++) begin
      if (due[7-i] !== seen[7-i]) begin
        $error("%s expected %0b actual %0b", lamp_names[i], due[7-i], seen[7-i]);
        lamp_faults = lamp_faults + 1;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Driver: ticks and register writes from the pending queue
  // ------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic                  busy;
    logic                  v_next;
    logic                  req_next;
    logic                  sel_next;
    logic                  en_next;
    logic                  wr_next;
    logic [ADDR_W-1:0]     addr_next;
    logic [APB_DATA_W-1:0] data_next;
    int                    gap_next;
    stim_item_t            item;
    if (rst) begin
      model_reset();
      tick_bus.valid       <= 1'b0;
      tick_bus.ped_request <= 1'b0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      gap_left             <= 0;
    end else begin
      busy      = 1'b0;
      v_next    = tick_bus.valid;
      req_next  = tick_bus.ped_request;
      sel_next  = psel;
      en_next   = penable;
      wr_next   = pwrite;
      addr_next = paddr;
      data_next = pwdata;
      gap_next  = gap_left;

      if (tick_bus.valid) begin
        if (tick_bus.ready) begin
          lamps_due.push_back(model_step(tick_bus.ped_request));
          ticks_taken = ticks_taken + 1;
          v_next      = 1'b0;
          gap_next    = pick_gap();
        end else begin
          busy = 1'b1;
        end
      end

      if (psel) begin
        if (penable && pready) begin
          model_config(cfg_reg_t'(paddr[ADDR_W-1:2]), pwdata);
          writes_done = writes_done + 1;
          sel_next    = 1'b0;
          en_next     = 1'b0;
          wr_next     = 1'b0;
          gap_next    = pick_gap();
        end else begin
          en_next = 1'b1;
          busy    = 1'b1;
        end
      end

      if (!busy) begin
        if (gap_next > 0) begin
          gap_next = gap_next - 1;
        end else if (pending.size() != 0) begin
          item = pending[0];
          if (item.kind == ITEM_TICK) begin
            if (!item.pause || lamps_due.size() == 0) begin
              void'(pending.pop_front());
              if (item.pause) pauses_done = pauses_done + 1;
              v_next   = 1'b1;
              req_next = item.press;
            end
          end else if (lamps_due.size() == 0) begin
            // Register writes only with nothing in flight
            void'(pending.pop_front());
            sel_next  = 1'b1;
            en_next   = 1'b0;
            wr_next   = 1'b1;
            addr_next = {item.cfg_idx, 2'b00};
            data_next = item.value;
          end
        end
      end

      tick_bus.valid       <= v_next;
      tick_bus.ped_request <= req_next;
      psel                 <= sel_next;
      penable              <= en_next;
      pwrite               <= wr_next;
      paddr                <= addr_next;
      pwdata               <= data_next;
      gap_left             <= gap_next;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: take lamp sets with random back-pressure and compare
  // ------------------------------------------------------------------
  always @(posedge clk) begin : watch
    lamp_set_t seen;
    lamp_set_t due;
    int        stall_next;
    logic      rdy_next;
    if (rst) begin
      lamp_bus.ready <= 1'b0;
      stall_left     <= 0;
    end else begin
      if (lamp_bus.valid && lamp_bus.ready) begin
        seen = {lamp_bus.lamp_a_green, lamp_bus.lamp_a_yellow, lamp_bus.lamp_a_red,
                lamp_bus.lamp_b_green, lamp_bus.lamp_b_yellow, lamp_bus.lamp_b_red,
                lamp_bus.lamp_walk, lamp_bus.lamp_dont_walk};
        if (lamps_due.size() == 0) begin
          $error("lamp transfer with no tick behind it");
          lamp_faults = lamp_faults + 1;
        end else begin
          due = lamps_due.pop_front();
          check_lamps(due, seen);
          lamps_checked = lamps_checked + 1;
        end
      end
      stall_next = stall_left;
      if (stall_next > 0) begin
        stall_next = stall_next - 1;
        rdy_next   = 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        stall_next = pick_gap();
        rdy_next   = (stall_next == 0);
      end else begin
        rdy_next = 1'b1;
      end
      lamp_bus.ready <= rdy_next;
      stall_left     <= stall_next;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ------------------------------------------------------------------
  initial begin : stimulus
    int unsigned seg_len;
    int unsigned press_mode;
    int unsigned n_writes;
    cfg_reg_t    idx;
    logic        press;
    logic        pause;
    rst = 1'b1;

    // Opening set-up: short phases and a short walk, button held throughout
    add_write(REG_GREEN_A, 8'd2);
    add_write(REG_YELLOW_A, 8'd1);
    add_write(REG_RED_A, 8'd2);
    add_write(REG_GREEN_B, 8'd1);
    add_write(REG_YELLOW_B, 8'd1);
    add_write(REG_RED_B, 8'd3);
    add_write(REG_WALK, 8'd2);
    add_write(REG_BLINK, 8'd0);
    for (int k = 0; k < 180; k++) add_tick(1'b1, 1'b0);

    while (planned_ticks < TICK_TARGET) begin
      n_writes = $urandom_range(1, 4);
      for (int w = 0; w < int'(n_writes); w++) begin
        idx = cfg_reg_t'(REG_IDX_W'($urandom_range(0, 7)));
        if (idx == REG_BLINK) begin
          add_write(idx, ($urandom_range(0, 99) < 70) ? 8'd0 : 8'($urandom_range(1, 3)));
        end else begin
          add_write(idx, pick_secs());
        end
      end
      seg_len    = $urandom_range(20, 150);
      press_mode = $urandom_range(0, 3);
      for (int k = 0; k < int'(seg_len) && planned_ticks < TICK_TARGET; k++) begin
        case (press_mode)
          0:       press = ($urandom_range(0, 99) < 4);
          1:       press = 1'b1;
          2:       press = 1'b0;
          default: press = 1'($urandom_range(0, 1));
        endcase
        pause = (planned_ticks == TICK_TARGET / 2) || ($urandom_range(0, 199) == 0);
        if (pause) pause_planned = 1'b1;
        add_tick(press, pause);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending.size() != 0 || tick_bus.valid || psel || lamps_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks over %0d register writes, with %0d lamp sets checked.",
             ticks_taken, writes_done, lamps_checked);
    $display("Crossings completed: %0d; sender drained the results %0d time(s).",
             crossings_done, pauses_done);
    if (ticks_taken != planned_ticks || lamps_checked != planned_ticks) begin
      $error("ticks planned %0d, taken %0d, lamp sets checked %0d",
             planned_ticks, ticks_taken, lamps_checked);
      $display("FAIL");
    end else if (lamp_faults != 0 || !pause_planned) begin
      $display("FAIL");
    end else begin
      $display("PASS");
    end
    $finish;
  end

  initial begin : watchdog
    #LIMIT_NS;
    $error("run did not finish in time");
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tlcp_pkg.sv
rtl/tlcp_if.sv
rtl/tlcp_approach.sv
rtl/tlcp_walk.sv
rtl/traffic_light_controller_ped.sv
tb/sv/testbench.sv
